/* src/hibp_pkg.sv */
// shared types and constants for the history indexed branch predictor
package hibp_pkg;

  // table shape
  localparam int TABLE_ROWS   = 64;
  localparam int HISTORY_BITS = 4;
  localparam int IDX_W        = 16;
  localparam int ROW_W        = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int ADDR_W       = ROW_W + HISTORY_BITS;
  localparam int ENTRIES      = TABLE_ROWS * (1 << HISTORY_BITS);

  // row reduction by reciprocal multiply, exact for 16-bit index and rows up to 4096
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] ROW_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TABLE_ROWS) - 64'd1) / 64'(TABLE_ROWS));
  localparam int ROWS_W = $clog2(TABLE_ROWS + 1);
  localparam logic [ROWS_W-1:0] ROWS_K = ROWS_W'(TABLE_ROWS);

  // operation codes
  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] branch_index;
    logic             taken;
    logic             predicted;
  } req_item_t;

  typedef struct packed {
    logic predict_taken;
    logic mispredict;
  } rsp_item_t;

  // one table entry: prediction bit and pending-miss bit
  typedef struct packed {
    logic pred;
    logic miss;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_READ,
    ST_RMW
  } state_t;

endpackage

/* src/hibp_row_map.sv */
// branch index to table row: index modulo the row count
module hibp_row_map import hibp_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] branch_index,
  output logic [ROW_W-1:0] row
);

  localparam int PROD_W = IDX_W + RECIP_W;
  localparam int QR_W   = IDX_W + ROWS_W;

  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  quot;
  logic [QR_W-1:0]   quot_rows;
  logic [IDX_W-1:0]  rem;

  // quotient estimate, registered before the back multiply
  always_ff @(posedge clk) begin
    prod <= PROD_W'(branch_index) * PROD_W'(ROW_RECIP);
  end

  // remainder from the registered quotient
  always_comb begin
    quot      = prod[RECIP_SHIFT +: IDX_W];
    quot_rows = QR_W'(quot) * QR_W'(ROWS_K);
    rem       = branch_index - quot_rows[IDX_W-1:0];
    row       = rem[ROW_W-1:0];
  end

endmodule

/* src/hibp_table.sv */
// prediction table memory, one write port and one registered read port
module hibp_table import hibp_pkg::*; (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/history_indexed_branch_predictor.sv */
// top level of the two-level history indexed branch predictor
//
//   channel | signals                      | direction | contents
//   --------+------------------------------+-----------+------------------------------
//   req     | req_valid, req_ready, req    | in        | func, branch_index, taken, predicted
//   rsp     | rsp_valid, rsp_ready, rsp    | out       | predict_taken, mispredict
//
// each item steps through accept, quotient multiply, table read and read-modify-write
// in turn, and a new item is accepted only after the last one's write-back
// after reset a clearing pass writes all 1024 table entries, one per cycle,
// and req_ready stays low until that pass ends
// a response that is not yet taken holds the next item in its write-back state
module history_indexed_branch_predictor import hibp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  state_t                  state, state_next;
  logic [ADDR_W-1:0]       clr_addr;
  req_item_t               item;
  logic [HISTORY_BITS-1:0] history, history_next;
  logic [HISTORY_BITS:0]   history_cat;
  logic [ROW_W-1:0]        row;
  tbl_wr_t                 tbl_wr;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  entry_t                  rd_data;
  entry_t                  entry_next;
  rsp_item_t               result;
  logic                    miss;
  logic                    load_rsp;
  logic                    rsp_free;

  hibp_row_map u_row_map (
    .clk          (clk),
    .branch_index (item.branch_index),
    .row          (row)
  );

  hibp_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // state register and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // held request item
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

  // entry update and result
  always_comb begin
    miss       = item.predicted != item.taken;
    entry_next = rd_data;
    if (miss) begin
      if (rd_data.miss) begin
        entry_next.pred = ~rd_data.pred;
        entry_next.miss = 1'b0;
      end else begin
        entry_next.miss = 1'b1;
      end
    end else begin
      entry_next.miss = 1'b0;
    end
    if (item.func == FUNC_RESOLVE) begin
      result.predict_taken = 1'b0;
      result.mispredict    = miss;
    end else begin
      result.predict_taken = rd_data.pred;
      result.mispredict    = 1'b0;
    end
    history_cat  = {item.taken, history};
    history_next = history_cat[HISTORY_BITS:1];
  end

  // next state, table access and handshake
  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = {row, history};
    tbl_wr.en   = 1'b0;
    tbl_wr.addr = rd_addr;
    tbl_wr.data = entry_next;
    load_rsp    = 1'b0;
    rsp_free    = !rsp_valid || rsp_ready;
    case (state)
      ST_CLEAR: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = clr_addr;
        tbl_wr.data = '0;
        if (clr_addr == ADDR_W'(ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_RMW;
      end
      ST_RMW: begin
        if (rsp_free) begin
          load_rsp   = 1'b1;
          tbl_wr.en  = item.func == FUNC_RESOLVE;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // history register
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (load_rsp && item.func == FUNC_RESOLVE) begin
      history <= history_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= result;
    end
  end

  // clearing pass writes zero entries
  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> tbl_wr.en && tbl_wr.data == '0)
    else $error("clearing pass must write zero entries");

  // table writes only during clearing or write-back
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |-> state == ST_CLEAR || state == ST_RMW)
    else $error("table write outside clear or write-back");

  // history moves only after a resolve write-back
  a_history_update: assert property (@(posedge clk) disable iff (rst)
    history != $past(history) |-> $past(state) == ST_RMW && $past(item.func) == FUNC_RESOLVE)
    else $error("history changed without a resolve");

  // a response appears only out of write-back
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_RMW)
    else $error("response raised outside write-back");

endmodule

/* verif/tb.sv */
// testbench for the history indexed branch predictor: queued stimulus, in-line predictor, checker
`timescale 1ns / 100ps

module tb;
  import hibp_pkg::*;

  localparam int COLS      = 1 << HISTORY_BITS;
  localparam int N_RANDOM  = 1200;
  localparam int N_HOT     = 8;
  localparam int TAIL_CYC  = 20;

  // one queued request with its lead-in gap
  typedef struct {
    req_item_t   item;
    int unsigned gap;
    bit          drain;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  queued_req_t branch_stream[$];
  rsp_item_t   due_results[$];

  // predictor copy of the table and history
  bit                    pred_bit[ENTRIES];
  bit                    miss_bit[ENTRIES];
  bit [HISTORY_BITS-1:0] hist_reg;

  int unsigned err_cnt = 0;
  int unsigned rsp_hold = 0;
  bit          rsp_calm = 1'b0;

  history_indexed_branch_predictor u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // expected result of one accepted request, updates the predictor state
  function automatic rsp_item_t gselect_step(req_item_t r);
    rsp_item_t   res;
    int unsigned slot;
    res  = '0;
    slot = (int'(r.branch_index) % TABLE_ROWS) * COLS + int'(hist_reg);
    if (r.func == FUNC_PREDICT) begin
      res.predict_taken = pred_bit[slot];
    end else begin
      if (r.predicted != r.taken) begin
        // second miss in a row flips the entry
        if (miss_bit[slot]) begin
          pred_bit[slot] = ~pred_bit[slot];
          miss_bit[slot] = 1'b0;
        end else begin
          miss_bit[slot] = 1'b1;
        end
        res.mispredict = 1'b1;
      end else begin
        miss_bit[slot] = 1'b0;
      end
      hist_reg = {r.taken, hist_reg[HISTORY_BITS-1:1]};
    end
    return res;
  endfunction

  // idle length: mostly short, a few long, none in calm stretches
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(logic func, logic [IDX_W-1:0] idx, logic tk, logic pr, bit calm,
                         bit drain);
    queued_req_t q;
    q.item.func         = func;
    q.item.branch_index = idx;
    q.item.taken        = tk;
    q.item.predicted    = pr;
    q.gap               = pick_gap(calm);
    q.drain             = drain;
    branch_stream.insert(branch_stream.size(), q);
  endtask

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("mismatch %s: expected %0b got %0b", name, want, got);
    end
  endtask

  // request driver, fed from branch_stream
  always @(posedge clk) begin
    bit busy;
    bit nv;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      busy = req_valid && !req_ready;
      nv   = busy;
      if (!busy && branch_stream.size() > 0) begin
        if (branch_stream[0].gap > 0) begin
          branch_stream[0].gap--;
        end else if (!(branch_stream[0].drain &&
                       (due_results.size() > 0 || (req_valid && req_ready)))) begin
          req <= branch_stream[0].item;
          nv  = 1'b1;
          void'(branch_stream.pop_front());
        end
      end
      req_valid <= nv;
    end
  end

  // response ready with random stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) rsp_calm = ~rsp_calm;
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
        if ($urandom_range(0, 9) < 3) rsp_hold = pick_gap(rsp_calm);
      end
    end
  end

  // monitor: predict on request accept, check on response accept
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst) begin
      if (req_valid && req_ready) due_results.insert(due_results.size(), gselect_step(req));
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected item: got predict_taken %0b mispredict %0b",
                     rsp.predict_taken, rsp.mispredict);
        end else begin
          want = due_results.pop_front();
          check_field("predict_taken", want.predict_taken, rsp.predict_taken);
          check_field("mispredict", want.mispredict, rsp.mispredict);
        end
      end
    end
  end

  // run limit
  initial begin
    #1000000;
    $display("tb: errors");
    $finish;
  end

  // stimulus and end of run
  initial begin
    logic [IDX_W-1:0] hot[N_HOT];
    bit               lean[N_HOT];
    int unsigned      n;
    int unsigned      h;
    int unsigned      r;
    bit               calm;
    logic             tk;
    logic             pr;
    logic [IDX_W-1:0] idx;

    hist_reg = '0;
    foreach (pred_bit[i]) begin
      pred_bit[i] = 1'b0;
      miss_bit[i] = 1'b0;
    end

    // extremes of the index, aliasing rows
    add_req(FUNC_PREDICT, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_PREDICT, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_PREDICT, 16'(TABLE_ROWS - 1), 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_PREDICT, 16'(TABLE_ROWS), 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_RESOLVE, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_RESOLVE, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
    // repeated taken misses fill the history, then two misses on one entry flip it
    repeat (6) add_req(FUNC_RESOLVE, 16'd5, 1'b1, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_PREDICT, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_PREDICT, 16'(5 + TABLE_ROWS), 1'b0, 1'b0, 1'b0, 1'b0);
    // miss, hit, miss: the hit clears the pending miss
    add_req(FUNC_RESOLVE, 16'd9, 1'b1, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_RESOLVE, 16'd9, 1'b1, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_RESOLVE, 16'd9, 1'b1, 1'b0, 1'b0, 1'b0);
    add_req(FUNC_PREDICT, 16'd9, 1'b0, 1'b0, 1'b0, 1'b0);
    // resolve uses the given prediction even against a set table bit
    add_req(FUNC_RESOLVE, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0);
    // lookup ignores taken and predicted
    add_req(FUNC_PREDICT, 16'd5, 1'b1, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_RESOLVE, 16'h8000, 1'b0, 1'b1, 1'b0, 1'b0);
    add_req(FUNC_PREDICT, 16'h8000, 1'b1, 1'b0, 1'b0, 1'b0);

    // hot branches with a taken lean
    foreach (hot[i]) begin
      hot[i]  = 16'($urandom_range(0, 65535));
      lean[i] = 1'($urandom_range(0, 1));
    end

    // random part: mostly predict/resolve pairs on hot branches, some noise
    n    = 0;
    calm = 1'b0;
    while (n < N_RANDOM) begin
      if (n % 100 < 2) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) begin
        h   = $urandom_range(0, N_HOT - 1);
        idx = hot[h] + 16'(TABLE_ROWS * $urandom_range(0, 1) * $urandom_range(0, 3));
        tk  = ($urandom_range(0, 9) < 8) ? lean[h] : ~lean[h];
        pr  = ($urandom_range(0, 9) < 7) ? lean[h] : 1'($urandom_range(0, 1));
        add_req(FUNC_PREDICT, idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), calm,
                1'b0);
        add_req(FUNC_RESOLVE, idx, tk, pr, calm, 1'b0);
        n += 2;
      end else begin
        // noise items near the middle of the random part wait for a full drain
        add_req(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), calm,
                (n >= N_RANDOM / 2 && n < N_RANDOM / 2 + 4));
        n++;
      end
    end
    branch_stream[18].drain = 1'b1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (branch_stream.size() > 0 || req_valid || due_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/hibp_pkg.sv
src/hibp_row_map.sv
src/hibp_table.sv
src/history_indexed_branch_predictor.sv
verif/tb.sv
